// ===== hw/rtl/mtq_pkg.sv =====
package mtq_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned MTQ_IN_W  = 20;
  localparam int unsigned MTQ_OUT_W = 16;

  // Extraction branch: positive trace, or largest diagonal element
  typedef enum logic [1:0] {
    MTQ_BR_W = 2'd0,
    MTQ_BR_X = 2'd1,
    MTQ_BR_Y = 2'd2,
    MTQ_BR_Z = 2'd3
  } mtq_branch_e;

  // Upper 3x3 of a column-major matrix, signed Q5.F
  typedef struct packed {
    logic signed [MTQ_IN_W-1:0] col0_x;
    logic signed [MTQ_IN_W-1:0] col0_y;
    logic signed [MTQ_IN_W-1:0] col0_z;
    logic signed [MTQ_IN_W-1:0] col1_x;
    logic signed [MTQ_IN_W-1:0] col1_y;
    logic signed [MTQ_IN_W-1:0] col1_z;
    logic signed [MTQ_IN_W-1:0] col2_x;
    logic signed [MTQ_IN_W-1:0] col2_y;
    logic signed [MTQ_IN_W-1:0] col2_z;
  } mtq_in_t;

  // Unit quaternion, signed Q1.F
  typedef struct packed {
    logic signed [MTQ_OUT_W-1:0] quat_w;
    logic signed [MTQ_OUT_W-1:0] quat_x;
    logic signed [MTQ_OUT_W-1:0] quat_y;
    logic signed [MTQ_OUT_W-1:0] quat_z;
  } mtq_out_t;

endpackage

// ===== hw/rtl/mtq_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, LANES in parallel.
// All stages move together on en_i.
module mtq_isqrt #(
  parameter int unsigned IW    = 40,
  parameter int unsigned LANES = 1,
  parameter int unsigned PW    = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [LANES-1:0][IW-1:0]       rad_i,
  input  logic [PW-1:0]                  pay_i,
  output logic                           valid_o,
  output logic [LANES-1:0][IW/2-1:0]     root_o,
  output logic [PW-1:0]                  pay_o
);

  localparam int unsigned OW = IW / 2;
  localparam int unsigned RW = OW + 3;

  logic [LANES-1:0][IW-1:0] rad_q  [OW];
  logic [LANES-1:0][RW-1:0] rem_q  [OW];
  logic [LANES-1:0][OW-1:0] root_q [OW];
  logic [PW-1:0]            pay_q  [OW];
  logic                     vld_q  [OW];

  for (genvar g = 0; g < OW; g++) begin : g_stage
    logic [LANES-1:0][IW-1:0] rad_s, rad_n;
    logic [LANES-1:0][RW-1:0] rem_s, rem_n;
    logic [LANES-1:0][OW-1:0] root_s, root_n;
    logic [PW-1:0]            pay_s;
    logic                     vld_s;

    if (g == 0) begin : g_first
      assign rad_s  = rad_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign pay_s  = pay_i;
      assign vld_s  = valid_i;
    end else begin : g_next
      assign rad_s  = rad_q[g-1];
      assign rem_s  = rem_q[g-1];
      assign root_s = root_q[g-1];
      assign pay_s  = pay_q[g-1];
      assign vld_s  = vld_q[g-1];
    end

    // Bring down two radicand bits, try subtracting 4*root+1
    always_comb begin : c_step
      logic [RW-1:0] acc;
      logic [RW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        acc   = {rem_s[l][RW-3:0], rad_s[l][IW-1:IW-2]};
        trial = {1'b0, root_s[l], 2'b01};
        rad_n[l] = {rad_s[l][IW-3:0], 2'b00};
        if (acc >= trial) begin
          rem_n[l]  = acc - trial;
          root_n[l] = {root_s[l][OW-2:0], 1'b1};
        end else begin
          rem_n[l]  = acc;
          root_n[l] = {root_s[l][OW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g]  <= rad_n;
        rem_q[g]  <= rem_n;
        root_q[g] <= root_n;
        pay_q[g]  <= pay_s;
      end
    end
  end

  assign valid_o = vld_q[OW-1];
  assign root_o  = root_q[OW-1];
  assign pay_o   = pay_q[OW-1];

endmodule

// ===== hw/rtl/mtq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, LANES numerators
// over one shared divisor. The quotient must stay below 2^QW.
// All stages move together on en_i.
module mtq_div #(
  parameter int unsigned NW    = 35,
  parameter int unsigned DW    = 20,
  parameter int unsigned QW    = 15,
  parameter int unsigned LANES = 3,
  parameter int unsigned PW    = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][NW-1:0]  num_i,
  input  logic [DW-1:0]             den_i,
  input  logic [PW-1:0]             pay_i,
  output logic                      valid_o,
  output logic [LANES-1:0][QW-1:0]  quot_o,
  output logic [PW-1:0]             pay_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned RW = ((HW > DW) ? HW : DW) + 1;

  logic [LANES-1:0][RW-1:0] rem_q [QW];
  logic [LANES-1:0][QW-1:0] lo_q  [QW];
  logic [LANES-1:0][QW-1:0] quo_q [QW];
  logic [DW-1:0]            den_q [QW];
  logic [PW-1:0]            pay_q [QW];
  logic                     vld_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [LANES-1:0][RW-1:0] rem_s, rem_n;
    logic [LANES-1:0][QW-1:0] lo_s, lo_n;
    logic [LANES-1:0][QW-1:0] quo_s, quo_n;
    logic [DW-1:0]            den_s;
    logic [PW-1:0]            pay_s;
    logic                     vld_s;

    if (g == 0) begin : g_first
      // Upper numerator part is below the divisor by the quotient bound
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_s[l] = RW'(num_i[l][NW-1:QW]);
          lo_s[l]  = num_i[l][QW-1:0];
        end
      end
      assign quo_s = '0;
      assign den_s = den_i;
      assign pay_s = pay_i;
      assign vld_s = valid_i;
    end else begin : g_next
      assign rem_s = rem_q[g-1];
      assign lo_s  = lo_q[g-1];
      assign quo_s = quo_q[g-1];
      assign den_s = den_q[g-1];
      assign pay_s = pay_q[g-1];
      assign vld_s = vld_q[g-1];
    end

    // Shift in one numerator bit, subtract the divisor when it fits
    always_comb begin : c_step
      logic [RW-1:0] acc;
      logic [RW-1:0] dx;
      dx = RW'(den_s);
      for (int l = 0; l < LANES; l++) begin
        acc     = {rem_s[l][RW-2:0], lo_s[l][QW-1]};
        lo_n[l] = {lo_s[l][QW-2:0], 1'b0};
        if (acc >= dx) begin
          rem_n[l] = acc - dx;
          quo_n[l] = {quo_s[l][QW-2:0], 1'b1};
        end else begin
          rem_n[l] = acc;
          quo_n[l] = {quo_s[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_n;
        lo_q[g]  <= lo_n;
        quo_q[g] <= quo_n;
        den_q[g] <= den_s;
        pay_q[g] <= pay_s;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule

// ===== hw/rtl/matrix_to_quaternion_top.sv =====
// Channel | Dir | Handshake                 | Item
// in      | in  | in_valid_i / in_stall_o   | in_data_i  (mtq_in_t, nine Q5.F elements)
// out     | out | out_valid_o / out_stall_i | out_data_o (mtq_out_t, four Q1.F values)
//
// One item enters every cycle while in_stall_o is low; the path runs through three
// square-root pipelines and three divider pipelines in series, one bit per stage.
// Reset clears only the valid bits of the stages, including that of the output register.
// The whole pipeline holds while the output register has an item that is stalled;
// in_stall_o is then high.
module matrix_to_quaternion_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mtq_pkg::mtq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mtq_pkg::mtq_out_t out_data_o
);

  import mtq_pkg::*;

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned SQ_W  = 2 * MTQ_IN_W;     // column sum of squares
  localparam int unsigned LEN_W = MTQ_IN_W;         // column length
  localparam int unsigned CN_W  = MTQ_IN_W + F + 1; // column numerator
  localparam int unsigned CQ_W  = F + 1;            // normalized magnitude
  localparam int unsigned R_W   = F + 2;            // normalized element, signed
  localparam int unsigned T_W   = F + 4;            // trace, sums, differences
  localparam int unsigned RAD_W = 2 * F + 4;        // square root operand
  localparam int unsigned RT_W  = RAD_W / 2;        // square root result
  localparam int unsigned D_W   = RT_W + 1;         // 2*root
  localparam int unsigned QN_W  = 2 * F + 3;        // component numerator
  localparam int unsigned QQ_W  = F + 2;            // component magnitude
  localparam int unsigned QC_W  = F + 3;            // component, signed
  localparam int unsigned NN_W  = 2 * F + 3;        // renormalize numerator
  localparam int unsigned P2_W  = 2 + 3 * T_W;
  localparam int unsigned P3_W  = 2 + 3 + RT_W;
  localparam int unsigned P4_W  = 4 * QC_W;
  localparam int unsigned P5_W  = 1 + 4 + 4 * QC_W;

  localparam logic signed [T_W-1:0] ONE_T  = T_W'(2 ** F);
  localparam logic signed [31:0]    ONE_32 = 32'(2 ** F);
  localparam logic signed [31:0]    OMAX   = 32'(2 ** (MTQ_OUT_W - 1) - 1);
  localparam logic signed [31:0]    OMIN   = -32'(2 ** (MTQ_OUT_W - 1));

  // Global advance: every stage moves unless the output item is stalled
  logic adv;
  logic out_valid_q;
  mtq_out_t out_data_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Elements in input order: index = column*3 + row
  logic signed [MTQ_IN_W-1:0] m_in [9];
  assign m_in[0] = in_data_i.col0_x;
  assign m_in[1] = in_data_i.col0_y;
  assign m_in[2] = in_data_i.col0_z;
  assign m_in[3] = in_data_i.col1_x;
  assign m_in[4] = in_data_i.col1_y;
  assign m_in[5] = in_data_i.col1_z;
  assign m_in[6] = in_data_i.col2_x;
  assign m_in[7] = in_data_i.col2_y;
  assign m_in[8] = in_data_i.col2_z;

  // ---------------- Stage 1: element squares
  logic                       v1_q;
  logic signed [MTQ_IN_W-1:0] m1_q  [9];
  logic [SQ_W-1:0]            sq1_q [9];
  logic [SQ_W-1:0]            sq1_d [9];

  always_comb begin
    logic signed [SQ_W-1:0] mw;
    for (int k = 0; k < 9; k++) begin
      mw       = SQ_W'(m_in[k]);
      sq1_d[k] = mw * mw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q  <= m_in;
      sq1_q <= sq1_d;
    end
  end

  // ---------------- Stage 2: column sums of squares
  logic                       v2_q;
  logic signed [MTQ_IN_W-1:0] m2_q   [9];
  logic [2:0][SQ_W-1:0]       sum2_q;
  logic [9*MTQ_IN_W-1:0]      m2_pk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_q <= m1_q;
      for (int c = 0; c < 3; c++) begin
        sum2_q[c] <= sq1_q[3*c] + sq1_q[3*c+1] + sq1_q[3*c+2];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m2_pk[k*MTQ_IN_W +: MTQ_IN_W] = m2_q[k];
    end
  end

  // Column lengths
  logic                   vc_o;
  logic [2:0][LEN_W-1:0]  col_len;
  logic [9*MTQ_IN_W-1:0]  mc_pk;

  mtq_isqrt #(
    .IW    (SQ_W),
    .LANES (3),
    .PW    (9 * MTQ_IN_W)
  ) u_col_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .rad_i   (sum2_q),
    .pay_i   (m2_pk),
    .valid_o (vc_o),
    .root_o  (col_len),
    .pay_o   (mc_pk)
  );

  // ---------------- Stage 3: column division operands, length floored at 1
  logic                       v3_q;
  logic [2:0][2:0][CN_W-1:0]  num3_q;
  logic [2:0][LEN_W-1:0]      den3_q;
  logic [2:0][2:0]            sgn3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= vc_o;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [LEN_W-1:0]           len;
    logic signed [MTQ_IN_W-1:0] mv;
    logic [MTQ_IN_W-1:0]        mag;
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        len = (col_len[c] == '0) ? LEN_W'(1) : col_len[c];
        den3_q[c] <= len;
        for (int r = 0; r < 3; r++) begin
          mv  = mc_pk[(3*c+r)*MTQ_IN_W +: MTQ_IN_W];
          mag = mv[MTQ_IN_W-1] ? MTQ_IN_W'(-mv) : MTQ_IN_W'(mv);
          num3_q[c][r] <= (CN_W'(mag) << F) + CN_W'(len >> 1);
          sgn3_q[c][r] <= mv[MTQ_IN_W-1];
        end
      end
    end
  end

  // Column normalization
  logic [2:0]                 vd_o;
  logic [2:0][2:0][CQ_W-1:0]  colq;
  logic [2:0][2:0]            cols;

  for (genvar c = 0; c < 3; c++) begin : g_col_div
    mtq_div #(
      .NW    (CN_W),
      .DW    (LEN_W),
      .QW    (CQ_W),
      .LANES (3),
      .PW    (3)
    ) u_col_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v3_q),
      .num_i   (num3_q[c]),
      .den_i   (den3_q[c]),
      .pay_i   (sgn3_q[c]),
      .valid_o (vd_o[c]),
      .quot_o  (colq[c]),
      .pay_o   (cols[c])
    );
  end

  // ---------------- Stage 4: signed normalized elements
  logic                  v4_q;
  logic signed [R_W-1:0] r4_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= &vd_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          r4_q[3*c+r] <= cols[c][r] ? -R_W'(colq[c][r]) : R_W'(colq[c][r]);
        end
      end
    end
  end

  // ---------------- Stage 5: trace, branch, candidate radicands, cross terms
  // r(row,col) = r4_q[col*3 + row]
  logic signed [T_W-1:0] r00, r11, r22, r01, r10, r02, r20, r12, r21, trace;
  assign r00   = T_W'(r4_q[0]);
  assign r10   = T_W'(r4_q[1]);
  assign r20   = T_W'(r4_q[2]);
  assign r01   = T_W'(r4_q[3]);
  assign r11   = T_W'(r4_q[4]);
  assign r21   = T_W'(r4_q[5]);
  assign r02   = T_W'(r4_q[6]);
  assign r12   = T_W'(r4_q[7]);
  assign r22   = T_W'(r4_q[8]);
  assign trace = r00 + r11 + r22;

  logic                  v5_q;
  mtq_branch_e           br5_q;
  logic signed [T_W-1:0] radc5_q [4];
  logic signed [T_W-1:0] ds5_q   [6];  // d21, d02, d10, s01, s02, s12
  mtq_branch_e           br5_d;

  // Strict compares, ties fall to the later axis
  always_comb begin
    priority if (trace > 0) begin
      br5_d = MTQ_BR_W;
    end else if (r00 > r11 && r00 > r22) begin
      br5_d = MTQ_BR_X;
    end else if (r11 > r22) begin
      br5_d = MTQ_BR_Y;
    end else begin
      br5_d = MTQ_BR_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      br5_q      <= br5_d;
      radc5_q[0] <= trace + ONE_T;
      radc5_q[1] <= ONE_T + r00 - r11 - r22;
      radc5_q[2] <= ONE_T + r11 - r00 - r22;
      radc5_q[3] <= ONE_T + r22 - r00 - r11;
      ds5_q[0]   <= r21 - r12;
      ds5_q[1]   <= r02 - r20;
      ds5_q[2]   <= r10 - r01;
      ds5_q[3]   <= r01 + r10;
      ds5_q[4]   <= r02 + r20;
      ds5_q[5]   <= r12 + r21;
    end
  end

  // ---------------- Stage 6: select radicand and the three numerators
  logic                  v6_q;
  logic [0:0][RAD_W-1:0] rad6_q;
  logic [P2_W-1:0]       p6_q;
  logic signed [T_W-1:0] rad_sel;
  logic signed [T_W-1:0] n6 [3];

  always_comb begin
    unique case (br5_q)
      MTQ_BR_W: begin
        rad_sel = radc5_q[0];
        n6[0] = ds5_q[0]; n6[1] = ds5_q[1]; n6[2] = ds5_q[2];
      end
      MTQ_BR_X: begin
        rad_sel = radc5_q[1];
        n6[0] = ds5_q[0]; n6[1] = ds5_q[3]; n6[2] = ds5_q[4];
      end
      MTQ_BR_Y: begin
        rad_sel = radc5_q[2];
        n6[0] = ds5_q[1]; n6[1] = ds5_q[3]; n6[2] = ds5_q[5];
      end
      default: begin
        rad_sel = radc5_q[3];
        n6[0] = ds5_q[2]; n6[1] = ds5_q[4]; n6[2] = ds5_q[5];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad6_q[0] <= (rad_sel > 0) ? (RAD_W'(rad_sel) << F) : '0;
      p6_q      <= {br5_q, n6[0], n6[1], n6[2]};
    end
  end

  // Branch root
  logic                  vr_o;
  logic [0:0][RT_W-1:0]  root_w;
  logic [P2_W-1:0]       pr_o;

  mtq_isqrt #(
    .IW    (RAD_W),
    .LANES (1),
    .PW    (P2_W)
  ) u_root_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v6_q),
    .rad_i   (rad6_q),
    .pay_i   (p6_q),
    .valid_o (vr_o),
    .root_o  (root_w),
    .pay_o   (pr_o)
  );

  // ---------------- Stage 7: component division operands, half of the root
  logic                       v7_q;
  logic [2:0][QN_W-1:0]       num7_q;
  logic [D_W-1:0]             den7_q;
  logic [P3_W-1:0]            p7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= vr_o;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [RT_W-1:0]       root;
    logic [RT_W-1:0]       half;
    logic signed [T_W-1:0] nv;
    logic [T_W-2:0]        mag;
    logic [2:0]            sg;
    if (adv) begin
      root = (root_w[0] == '0) ? RT_W'(1) : root_w[0];
      half = RT_W'(({1'b0, root} + (RT_W+1)'(1)) >> 1);
      for (int k = 0; k < 3; k++) begin
        nv    = pr_o[(2-k)*T_W +: T_W];
        mag   = nv[T_W-1] ? (T_W-1)'(-nv) : (T_W-1)'(nv);
        sg[k] = nv[T_W-1];
        num7_q[k] <= (QN_W'(mag) << F) + QN_W'(root);
      end
      den7_q <= {root, 1'b0};
      p7_q   <= {pr_o[P2_W-1 -: 2], sg, half};
    end
  end

  logic                  vq_o;
  logic [2:0][QQ_W-1:0]  cq;
  logic [P3_W-1:0]       pq_o;

  mtq_div #(
    .NW    (QN_W),
    .DW    (D_W),
    .QW    (QQ_W),
    .LANES (3),
    .PW    (P3_W)
  ) u_comp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .den_i   (den7_q),
    .pay_i   (p7_q),
    .valid_o (vq_o),
    .quot_o  (cq),
    .pay_o   (pq_o)
  );

  // ---------------- Stage 8: place components by branch
  logic                   v8_q;
  logic signed [QC_W-1:0] q8_q [4];
  logic signed [QC_W-1:0] lane [3];
  logic signed [QC_W-1:0] hv;
  mtq_branch_e            br8;

  always_comb begin
    logic [2:0] sg;
    sg  = pq_o[RT_W +: 3];
    br8 = mtq_branch_e'(pq_o[P3_W-1 -: 2]);
    hv  = QC_W'(pq_o[RT_W-1:0]);
    for (int k = 0; k < 3; k++) begin
      lane[k] = sg[k] ? -QC_W'(cq[k]) : QC_W'(cq[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (adv) begin
      v8_q <= vq_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unique case (br8)
        MTQ_BR_W: begin
          q8_q[0] <= hv;      q8_q[1] <= lane[0]; q8_q[2] <= lane[1]; q8_q[3] <= lane[2];
        end
        MTQ_BR_X: begin
          q8_q[0] <= lane[0]; q8_q[1] <= hv;      q8_q[2] <= lane[1]; q8_q[3] <= lane[2];
        end
        MTQ_BR_Y: begin
          q8_q[0] <= lane[0]; q8_q[1] <= lane[1]; q8_q[2] <= hv;      q8_q[3] <= lane[2];
        end
        default: begin
          q8_q[0] <= lane[0]; q8_q[1] <= lane[1]; q8_q[2] <= lane[2]; q8_q[3] <= hv;
        end
      endcase
    end
  end

  // ---------------- Stage 9: component squares
  logic                   v9_q;
  logic signed [QC_W-1:0] q9_q  [4];
  logic [RAD_W-1:0]       sq9_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else if (adv) begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [2*QC_W-1:0] qw;
    if (adv) begin
      q9_q <= q8_q;
      for (int k = 0; k < 4; k++) begin
        qw       = (2*QC_W)'(q8_q[k]);
        sq9_q[k] <= RAD_W'(qw * qw);
      end
    end
  end

  // ---------------- Stage 10: quaternion squared length
  logic                  v10_q;
  logic [0:0][RAD_W-1:0] sum10_q;
  logic [P4_W-1:0]       p10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (adv) begin
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum10_q[0] <= sq9_q[0] + sq9_q[1] + sq9_q[2] + sq9_q[3];
      p10_q      <= {q9_q[0], q9_q[1], q9_q[2], q9_q[3]};
    end
  end

  logic                  vl_o;
  logic [0:0][RT_W-1:0]  qlen;
  logic [P4_W-1:0]       pl_o;

  mtq_isqrt #(
    .IW    (RAD_W),
    .LANES (1),
    .PW    (P4_W)
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v10_q),
    .rad_i   (sum10_q),
    .pay_i   (p10_q),
    .valid_o (vl_o),
    .root_o  (qlen),
    .pay_o   (pl_o)
  );

  // ---------------- Stage 11: renormalize operands; zero length passes through
  logic                  v11_q;
  logic [3:0][NN_W-1:0]  num11_q;
  logic [RT_W-1:0]       den11_q;
  logic [P5_W-1:0]       p11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
    end else if (adv) begin
      v11_q <= vl_o;
    end
  end

  always_ff @(posedge clk_i) begin
    logic                   zero;
    logic [RT_W-1:0]        dv;
    logic signed [QC_W-1:0] cv;
    logic [QC_W-2:0]        mag;
    logic [3:0]             sg;
    if (adv) begin
      zero = (qlen[0] == '0);
      dv   = zero ? RT_W'(1) : qlen[0];
      for (int k = 0; k < 4; k++) begin
        cv    = pl_o[(3-k)*QC_W +: QC_W];
        mag   = cv[QC_W-1] ? (QC_W-1)'(-cv) : (QC_W-1)'(cv);
        sg[k] = cv[QC_W-1];
        num11_q[k] <= (NN_W'(mag) << F) + NN_W'(dv >> 1);
      end
      den11_q <= dv;
      p11_q   <= {zero, sg, pl_o};
    end
  end

  logic                  vn_o;
  logic [3:0][QQ_W-1:0]  nq;
  logic [P5_W-1:0]       pn_o;

  mtq_div #(
    .NW    (NN_W),
    .DW    (RT_W),
    .QW    (QQ_W),
    .LANES (4),
    .PW    (P5_W)
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v11_q),
    .num_i   (num11_q),
    .den_i   (den11_q),
    .pay_i   (p11_q),
    .valid_o (vn_o),
    .quot_o  (nq),
    .pay_o   (pn_o)
  );

  // ---------------- Output register: select, saturate to +-ONE and 16 bits
  logic [MTQ_OUT_W-1:0] sat [4];

  always_comb begin
    logic                   zero;
    logic [3:0]             sg;
    logic signed [QC_W-1:0] cv;
    logic signed [31:0]     cw;
    zero = pn_o[P5_W-1];
    sg   = pn_o[P4_W +: 4];
    for (int k = 0; k < 4; k++) begin
      if (zero) begin
        cv = pn_o[(3-k)*QC_W +: QC_W];
      end else begin
        cv = sg[k] ? -QC_W'(nq[k]) : QC_W'(nq[k]);
      end
      cw = 32'(cv);
      if (cw > ONE_32) cw = ONE_32;
      if (cw < -ONE_32) cw = -ONE_32;
      if (cw > OMAX) cw = OMAX;
      if (cw < OMIN) cw = OMIN;
      sat[k] = MTQ_OUT_W'(cw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vn_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.quat_w <= sat[0];
      out_data_q.quat_x <= sat[1];
      out_data_q.quat_y <= sat[2];
      out_data_q.quat_z <= sat[3];
    end
  end

endmodule

// ===== verif/matrix_to_quaternion_top_test.sv =====
module matrix_to_quaternion_top_test;
  import mtq_pkg::*;

  localparam int FB = 14;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LATENCY = 5 * FB + 41;
  localparam longint CYCLE_LIMIT = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  mtq_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  mtq_out_t out_data_o;

  mtq_out_t quat_expected_q[$];
  int       mismatches = 0;
  longint   cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  matrix_to_quaternion_top #(.FRAC_BITS(FB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // floor(sqrt(v)), bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // divide rounding to nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    longint unsigned mag, ud, q;
    mag = (n < 0) ? longint'(-n) : n;
    ud = (d > 0) ? d : 1;
    q = (mag + ud / 2) / ud;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scaled_root(longint rad);
    longint unsigned u;
    longint r;
    u = (rad > 0) ? rad : 0;
    r = int_sqrt(u << FB);
    return (r > 0) ? r : 1;
  endfunction

  function automatic logic [15:0] clamp_q(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // expected quaternion of one matrix
  function automatic mtq_out_t matrix_quat(mtq_in_t m);
    longint e[3][3];
    longint r[3][3];
    longint q[4];
    longint unsigned sum;
    longint len, tr, root, den;
    mtq_out_t res;
    e[0][0] = m.col0_x; e[1][0] = m.col0_y; e[2][0] = m.col0_z;
    e[0][1] = m.col1_x; e[1][1] = m.col1_y; e[2][1] = m.col1_z;
    e[0][2] = m.col2_x; e[1][2] = m.col2_y; e[2][2] = m.col2_z;
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int k = 0; k < 3; k++) sum += longint'(e[k][c] * e[k][c]);
      len = int_sqrt(sum);
      if (len < 1) len = 1;
      for (int k = 0; k < 3; k++) r[k][c] = round_div(e[k][c] * ONE, len);
    end
    tr = r[0][0] + r[1][1] + r[2][2];
    if (tr > 0) begin
      root = scaled_root(tr + ONE);
      den = 2 * root;
      q[0] = round_div(root, 2);
      q[1] = round_div((r[2][1] - r[1][2]) * ONE, den);
      q[2] = round_div((r[0][2] - r[2][0]) * ONE, den);
      q[3] = round_div((r[1][0] - r[0][1]) * ONE, den);
    end else if (r[0][0] > r[1][1] && r[0][0] > r[2][2]) begin
      root = scaled_root(ONE + r[0][0] - r[1][1] - r[2][2]);
      den = 2 * root;
      q[0] = round_div((r[2][1] - r[1][2]) * ONE, den);
      q[1] = round_div(root, 2);
      q[2] = round_div((r[0][1] + r[1][0]) * ONE, den);
      q[3] = round_div((r[0][2] + r[2][0]) * ONE, den);
    end else if (r[1][1] > r[2][2]) begin
      root = scaled_root(ONE + r[1][1] - r[0][0] - r[2][2]);
      den = 2 * root;
      q[0] = round_div((r[0][2] - r[2][0]) * ONE, den);
      q[1] = round_div((r[0][1] + r[1][0]) * ONE, den);
      q[2] = round_div(root, 2);
      q[3] = round_div((r[1][2] + r[2][1]) * ONE, den);
    end else begin
      root = scaled_root(ONE + r[2][2] - r[0][0] - r[1][1]);
      den = 2 * root;
      q[0] = round_div((r[1][0] - r[0][1]) * ONE, den);
      q[1] = round_div((r[0][2] + r[2][0]) * ONE, den);
      q[2] = round_div((r[1][2] + r[2][1]) * ONE, den);
      q[3] = round_div(root, 2);
    end
    // renormalize unless the length is zero
    sum = 0;
    for (int k = 0; k < 4; k++) sum += longint'(q[k] * q[k]);
    len = int_sqrt(sum);
    if (len > 0)
      for (int k = 0; k < 4; k++) q[k] = round_div(q[k] * ONE, len);
    res.quat_w = clamp_q(q[0]);
    res.quat_x = clamp_q(q[1]);
    res.quat_y = clamp_q(q[2]);
    res.quat_z = clamp_q(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // send one matrix, holding it until accepted; valid drops only while idling
  task automatic send_matrix(input mtq_in_t m);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= m;
    quat_expected_q.push_back(matrix_quat(m));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic signed [19:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 20'sd524287;
      2: return -20'sd524288;
      3: return 0;
      default: return $signed(20'($urandom_range(2 * 16384))) - 20'sd16384;
    endcase
  endfunction

  // rotation-like matrix: signed permutation of the axes plus small noise
  function automatic mtq_in_t rand_rotation();
    logic signed [19:0] e[3][3];
    int p0, p1, p2;
    mtq_in_t m;
    p0 = $urandom_range(2);
    p1 = (p0 + 1 + $urandom_range(1)) % 3;
    p2 = 3 - p0 - p1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = $signed(20'($urandom_range(8000))) - 20'sd4000;
    e[p0][0] = $urandom_range(1) ? 20'sd16384 : -20'sd16384;
    e[p1][1] = $urandom_range(1) ? 20'sd16384 : -20'sd16384;
    e[p2][2] = $urandom_range(1) ? 20'sd16384 : -20'sd16384;
    m = '{e[0][0], e[1][0], e[2][0], e[0][1], e[1][1], e[2][1], e[0][2], e[1][2], e[2][2]};
    return m;
  endfunction

  function automatic mtq_in_t rand_matrix();
    mtq_in_t m;
    m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    return m;
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (quat_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i)
    out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // result checker
  always @(posedge clk_i) begin
    mtq_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_expected_q.size() == 0) begin
        report_mismatch("unexpected quaternion, quat_w", out_data_o.quat_w, 0);
      end else begin
        want = quat_expected_q.pop_front();
        if (out_data_o.quat_w !== want.quat_w)
          report_mismatch("quat_w", out_data_o.quat_w, want.quat_w);
        if (out_data_o.quat_x !== want.quat_x)
          report_mismatch("quat_x", out_data_o.quat_x, want.quat_x);
        if (out_data_o.quat_y !== want.quat_y)
          report_mismatch("quat_y", out_data_o.quat_y, want.quat_y);
        if (out_data_o.quat_z !== want.quat_z)
          report_mismatch("quat_z", out_data_o.quat_z, want.quat_z);
      end
    end
  end

  // watchdog
  always @(posedge clk_i)
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end

  // identity, each branch, zero columns, field extremes
  task automatic test_directed();
    mtq_in_t m;
    send_matrix('{20'sd16384, 0, 0, 0, 20'sd16384, 0, 0, 0, 20'sd16384});
    send_matrix('{20'sd16384, 0, 0, 0, -20'sd16384, 0, 0, 0, -20'sd16384});
    send_matrix('{-20'sd16384, 0, 0, 0, 20'sd16384, 0, 0, 0, -20'sd16384});
    send_matrix('{-20'sd16384, 0, 0, 0, -20'sd16384, 0, 0, 0, 20'sd16384});
    send_matrix('{-20'sd16384, 0, 0, 0, -20'sd16384, 0, 0, 0, -20'sd16384});
    send_matrix('0);
    send_matrix('{0, 0, 0, 0, 20'sd16384, 0, 0, 0, 20'sd16384});
    m = {9{20'sh7FFFF}};
    send_matrix(m);
    m = {9{20'sh80000}};
    send_matrix(m);
    send_matrix('{20'sd524287, -20'sd524288, 0, -20'sd524288, 20'sd524287, 0,
                  0, 0, -20'sd524288});
    send_matrix('{0, 20'sd16384, 0, -20'sd16384, 0, 0, 0, 0, 20'sd16384});
    send_matrix('{0, 0, 20'sd16384, 20'sd16384, 0, 0, 0, 20'sd16384, 0});
    m = {9{20'sh00001}};
    send_matrix(m);
    m = {9{20'shFFFFF}};
    send_matrix(m);
    m = {9{20'sh55555}};
    send_matrix(m);
    m = {9{20'shAAAAA}};
    send_matrix(m);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_matrix(($urandom_range(99) < 70) ? rand_rotation() : rand_matrix());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 30;
    recv_idle_pct = 71;
    test_random(250);
    drain_results();
    send_idle_pct = 71;
    recv_idle_pct = 30;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    drain_results();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && quat_expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
